FILE: hdl/gcr62_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr62_pkg
// Shared constants, types and the 6-and-2 nibble decode function.
// ----------------------------------------------------------------------------
package gcr62_pkg;

    localparam int unsigned AUX_COUNT           = 86;
    localparam int unsigned SECTOR_NIBBLES      = 342;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

    localparam int unsigned POS_W  = 9;
    localparam int unsigned ADDR_W = 7;
    localparam int unsigned VAL_W  = 6;
    localparam int unsigned GRP_W  = 2;

    localparam logic [POS_W-1:0]  POS_AUX_END = POS_W'(AUX_COUNT);
    localparam logic [POS_W-1:0]  POS_END     = POS_W'(SECTOR_NIBBLES);
    localparam logic [POS_W-1:0]  POS_LAST    = POS_W'(SECTOR_NIBBLES - 1);
    localparam logic [ADDR_W-1:0] SLOT_LAST   = ADDR_W'(AUX_COUNT - 1);

    // pair offset within an aux entry
    localparam logic [GRP_W-1:0] GRP_LOW  = 2'd0;
    localparam logic [GRP_W-1:0] GRP_MID  = 2'd1;
    localparam logic [GRP_W-1:0] GRP_HIGH = 2'd2;

    // one data-phase item on its way to the result side
    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] aux;
        logic [GRP_W-1:0] grp;
        logic [7:0]       idx;
        logic             last;
    } job_t;

    // disk nibble to 6-bit value; invalid nibbles give 0
    function automatic logic [VAL_W-1:0] gcr_decode(input logic [7:0] nib);
        logic [VAL_W-1:0] v;
        unique case (nib)
            8'h97: v = 6'h01;  8'h9A: v = 6'h02;  8'h9B: v = 6'h03;
            8'h9D: v = 6'h04;  8'h9E: v = 6'h05;  8'h9F: v = 6'h06;
            8'hA6: v = 6'h07;  8'hA7: v = 6'h08;  8'hAB: v = 6'h09;
            8'hAC: v = 6'h0A;  8'hAD: v = 6'h0B;  8'hAE: v = 6'h0C;
            8'hAF: v = 6'h0D;  8'hB2: v = 6'h0E;  8'hB3: v = 6'h0F;
            8'hB4: v = 6'h10;  8'hB5: v = 6'h11;  8'hB6: v = 6'h12;
            8'hB7: v = 6'h13;  8'hB9: v = 6'h14;  8'hBA: v = 6'h15;
            8'hBB: v = 6'h16;  8'hBC: v = 6'h17;  8'hBD: v = 6'h18;
            8'hBE: v = 6'h19;  8'hBF: v = 6'h1A;  8'hCB: v = 6'h1B;
            8'hCD: v = 6'h1C;  8'hCE: v = 6'h1D;  8'hCF: v = 6'h1E;
            8'hD3: v = 6'h1F;  8'hD6: v = 6'h20;  8'hD7: v = 6'h21;
            8'hD9: v = 6'h22;  8'hDA: v = 6'h23;  8'hDB: v = 6'h24;
            8'hDC: v = 6'h25;  8'hDD: v = 6'h26;  8'hDE: v = 6'h27;
            8'hDF: v = 6'h28;  8'hE5: v = 6'h29;  8'hE6: v = 6'h2A;
            8'hE7: v = 6'h2B;  8'hE9: v = 6'h2C;  8'hEA: v = 6'h2D;
            8'hEB: v = 6'h2E;  8'hEC: v = 6'h2F;  8'hED: v = 6'h30;
            8'hEE: v = 6'h31;  8'hEF: v = 6'h32;  8'hF2: v = 6'h33;
            8'hF3: v = 6'h34;  8'hF4: v = 6'h35;  8'hF5: v = 6'h36;
            8'hF6: v = 6'h37;  8'hF7: v = 6'h38;  8'hF9: v = 6'h39;
            8'hFA: v = 6'h3A;  8'hFB: v = 6'h3B;  8'hFC: v = 6'h3C;
            8'hFD: v = 6'h3D;  8'hFE: v = 6'h3E;  8'hFF: v = 6'h3F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // aux fragments are stored with their two bits swapped
    function automatic logic [1:0] pair_swap(input logic [1:0] p);
        return {p[0], p[1]};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/gcr62_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr62_front
// Input side: decode, running xor, sector position, aux store write/read.
// Data-phase nibbles leave in the following cycle as a job for the queue.
// ----------------------------------------------------------------------------
module gcr62_front
    import gcr62_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       nibble,
    input  wire logic             start_req,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [CNT_W-1:0] q_count,
    output logic                  job_valid,
    output job_t                  job
);

    logic [VAL_W-1:0]  xor_reg, xor_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;

    logic              s1_valid_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    logic [GRP_W-1:0]  s1_grp_reg;
    logic [7:0]        s1_idx_reg;
    logic              s1_last_reg;
    logic [VAL_W-1:0]  aux_rd_reg;

    logic [VAL_W-1:0]  aux_mem [0:AUX_COUNT-1];

    logic              accept;
    logic [VAL_W-1:0]  xor_eff, val;
    logic [POS_W-1:0]  pos_eff, j;
    logic [ADDR_W-1:0] slot_eff;
    logic [GRP_W-1:0]  grp_eff;
    logic              in_sector, aux_phase, data_phase;
    logic [CNT_W:0]    inflight;

    // an accepted item passes the front stage register before it lands in the queue; count what is ahead
    assign inflight = {1'b0, q_count} + (CNT_W+1)'(s1_valid_reg);
    assign full     = inflight >= (CNT_W+1)'(QUEUE_DEPTH);
    assign accept   = push && !full;

    assign xor_eff  = start_req ? '0 : xor_reg;
    assign pos_eff  = start_req ? '0 : pos_reg;
    assign slot_eff = start_req ? '0 : slot_reg;
    assign grp_eff  = start_req ? GRP_LOW : grp_reg;

    assign in_sector  = pos_eff < POS_END;
    assign aux_phase  = accept && in_sector && (pos_eff < POS_AUX_END);
    assign data_phase = accept && in_sector && (pos_eff >= POS_AUX_END);
    assign val        = xor_eff ^ gcr_decode(nibble);
    assign j          = pos_eff - POS_AUX_END;

    always_comb
    begin
        xor_next  = xor_reg;
        pos_next  = pos_reg;
        slot_next = slot_reg;
        grp_next  = grp_reg;
        if (accept) begin
            xor_next  = xor_eff;
            pos_next  = pos_eff;
            slot_next = slot_eff;
            grp_next  = grp_eff;
            if (in_sector) begin
                xor_next = val;
                pos_next = pos_eff + 1'b1;
            end
            if (data_phase) begin
                if (slot_eff == SLOT_LAST) begin
                    slot_next = '0;
                    grp_next  = grp_eff + 1'b1;
                end else begin
                    slot_next = slot_eff + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            xor_reg      <= '0;
            pos_reg      <= '0;
            slot_reg     <= '0;
            grp_reg      <= GRP_LOW;
            s1_valid_reg <= 1'b0;
        end else begin
            xor_reg      <= xor_next;
            pos_reg      <= pos_next;
            slot_reg     <= slot_next;
            grp_reg      <= grp_next;
            s1_valid_reg <= data_phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_phase) begin
            s1_val_reg  <= val;
            s1_grp_reg  <= grp_eff;
            s1_idx_reg  <= j[7:0];
            s1_last_reg <= (pos_eff == POS_LAST);
        end
    end

    // aux store: written during the aux phase, read during the data phase
    always_ff @(posedge clk)
    begin
        if (aux_phase)
            aux_mem[pos_eff[ADDR_W-1:0]] <= val;
        if (data_phase)
            aux_rd_reg <= aux_mem[slot_eff];
    end

    assign job_valid = s1_valid_reg;
    assign job.val   = s1_val_reg;
    assign job.aux   = aux_rd_reg;
    assign job.grp   = s1_grp_reg;
    assign job.idx   = s1_idx_reg;
    assign job.last  = s1_last_reg;

endmodule
`default_nettype wire

FILE: hdl/gcr62_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr62_queue
// Small job queue between the front and the result side.
// ----------------------------------------------------------------------------
module gcr62_queue
    import gcr62_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire job_t             wr_job,
    input  wire logic             rd_en,
    output job_t                  rd_job,
    output logic                  q_empty,
    output logic [CNT_W-1:0]      count
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    job_t             slots_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_rd;

    assign do_rd   = rd_en && (count_reg != '0);
    assign q_empty = (count_reg == '0);
    assign count   = count_reg;
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slots_reg[wr_ptr_reg] <= wr_job;
    end

endmodule
`default_nettype wire

FILE: hdl/gcr62_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr62_back
// Result side: assembles the data byte and holds it in the output register.
// ----------------------------------------------------------------------------
module gcr62_back
    import gcr62_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire job_t  head,
    output logic       q_pop,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic       last,
    output logic       empty,
    input  wire logic  pop
);

    logic       out_valid_reg;
    logic [7:0] byte_reg, idx_reg;
    logic       last_reg;
    logic [1:0] pair;
    logic       load;

    always_comb
    begin
        unique case (head.grp)
            GRP_LOW:  pair = head.aux[1:0];
            GRP_MID:  pair = head.aux[3:2];
            GRP_HIGH: pair = head.aux[5:4];
            default:  pair = '0;
        endcase
    end

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= {head.val, pair_swap(pair)};
            idx_reg  <= head.idx;
            last_reg <= head.last;
        end
    end

    assign empty      = !out_valid_reg;
    assign data_byte  = byte_reg;
    assign byte_index = idx_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

FILE: hdl/gcr_6_and_2_sector_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_6_and_2_sector_decoder
// 6-and-2 GCR sector data-field decoder, one disk nibble per transfer.
// ----------------------------------------------------------------------------
// Push the data-field nibbles of a sector in order, with start_req high on the
// first one. Each nibble is decoded and XORed with the previous value; the
// first 86 values fill the aux store and give no result, the next 256 each
// give one data byte with its byte_index, and last marks byte 255. The
// checksum nibble and anything after it are dropped until the next start_req.
// Without a start after reset the stream is taken as a sector from its first
// nibble. Invalid nibbles decode as zero. One nibble is taken every cycle
// while full is low; a data byte passes the front stage with the registered
// aux-store read, a job queue slot and the output register before it is on
// the result side. full rises only when the job queue, sized by QUEUE_DEPTH,
// could not take what is already in flight, i.e. when the result side is
// stalled.
// ----------------------------------------------------------------------------
module gcr_6_and_2_sector_decoder
    import gcr62_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input queue side
    input  wire logic [7:0] nibble,
    input  wire logic       start_req,
    input  wire logic       push,
    output logic            full,
    // result queue side
    output logic [7:0]      data_byte,
    output logic [7:0]      byte_index,
    output logic            last,
    output logic            empty,
    input  wire logic       pop
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             front_job, head_job;
    logic             front_job_valid;
    logic             q_empty, q_pop;
    logic [CNT_W-1:0] q_count;

    // front: accepts every transfer, tracks sector position, owns aux store
    gcr62_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .nibble    (nibble),
        .start_req (start_req),
        .push      (push),
        .full      (full),
        .q_count   (q_count),
        .job_valid (front_job_valid),
        .job       (front_job)
    );

    // decouples the front from result-side stalls
    gcr62_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_job_valid),
        .wr_job  (front_job),
        .rd_en   (q_pop),
        .rd_job  (head_job),
        .q_empty (q_empty),
        .count   (q_count)
    );

    // back: byte assembly and output register
    gcr62_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head_job),
        .q_pop      (q_pop),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 6-and-2 GCR sector data-field decoder.
// ----------------------------------------------------------------------------
// A short directed table runs first: invalid nibbles, a start-less sector
// after reset, extreme bytes and the last-byte flag, trailing nibbles, a
// restart in the middle of a sector, and back-to-back starts. Random sectors
// follow, most of them well formed with random, mostly valid nibbles, the rest cut
// short or plain noise. Every data byte that comes out is compared with a
// local model of the decoder. Both sides idle at random, the result side is
// held off once for a long stretch, and the sender drains between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcr62_pkg::AUX_COUNT;
    import gcr62_pkg::SECTOR_NIBBLES;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned DRAIN_CYCLES = 16;     // pipeline is three deep
    localparam int unsigned LONG_HOLD    = 400;    // more than one whole sector
    localparam int unsigned PHASE_ITEMS  = 156;
    localparam int unsigned N_DIR        = 18;

    // The 64 valid disk nibbles, in order of their 6-bit value.
    localparam logic [0:63][7:0] DISK_CODES = {
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       last;
    } sector_byte_t;

    // One directed row: a nibble sent reps times. Where has_want is set the
    // row is a single nibble whose byte is typed in by hand.
    typedef struct packed {
        logic [7:0]   nib;
        logic         st;
        logic [8:0]   reps;
        logic         has_want;
        sector_byte_t want;
    } disk_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic [7:0] nibble    = 8'h00;
    logic       start_req = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;

    always #5 clk = ~clk;

    gcr_6_and_2_sector_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .nibble     (nibble),
        .start_req  (start_req),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    // ------------------------------------------------------------------------
    // Decoder model: running XOR, nibble position and the aux fragments
    // ------------------------------------------------------------------------
    logic [5:0]   run_xor = '0;
    logic [8:0]   nib_pos = '0;
    logic [5:0]   aux_mem [AUX_COUNT];

    sector_byte_t byte_q [$];          // data bytes still owed by the DUT
    int unsigned  used_items = 0;      // nibbles that moved the model
    int unsigned  errors = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    bit           hold_armed = 1'b0;

    // Anything outside the 64 codes decodes like 0x96, i.e. to zero.
    function automatic logic [5:0] gcr_value(input logic [7:0] nib);
        for (int k = 0; k < 64; k++)
            if (DISK_CODES[k] == nib)
                return 6'(k);
        return 6'd0;
    endfunction

    // Advance the model by one accepted nibble. Returns 1 when a data byte
    // comes out of it; used tells whether the nibble was taken at all.
    function automatic bit decode_sector_nibble(input logic [7:0] nib, input logic st,
                                                output bit used, output sector_byte_t res);
        logic [5:0]  v;
        logic [5:0]  frag;
        int unsigned j;
        used = 1'b0;
        res  = '0;
        if (st)
        begin
            run_xor = '0;
            nib_pos = '0;
        end
        // past the checksum: dropped until the next start
        if (nib_pos >= SECTOR_NIBBLES)
            return 1'b0;
        used    = 1'b1;
        v       = run_xor ^ gcr_value(nib);
        run_xor = v;
        if (nib_pos < AUX_COUNT)
        begin
            aux_mem[nib_pos] = v;
            nib_pos++;
            return 1'b0;
        end
        j = nib_pos - AUX_COUNT;
        nib_pos++;
        // slot j mod 86, pair 0/1/2 picked by j div 86; bits stored swapped
        frag = aux_mem[j % AUX_COUNT] >> (2 * (j / AUX_COUNT));
        res.data_byte  = {v, frag[0], frag[1]};
        res.byte_index = j[7:0];
        res.last       = (j == 255);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one nibble, idling first at the current rate, and hold it until
    // the transfer. push stays high into the next call unless that one idles.
    task automatic send_nibble(input logic [7:0] nib, input logic st,
                               input bit has_want, input sector_byte_t want);
        sector_byte_t res;
        bit           used;
        bit           produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push      <= 1'b0;
            nibble    <= 8'($urandom);
            start_req <= 1'($urandom);
            @(posedge clk);
        end
        push      <= 1'b1;
        nibble    <= nib;
        start_req <= st;
        do
            @(posedge clk);
        while (full);
        // transfer took place at this edge
        produced = decode_sector_nibble(nib, st, used, res);
        if (has_want)
            byte_q.push_back(want);
        else if (produced)
            byte_q.push_back(res);
        if (used)
            used_items++;
    endtask

    // Stop offering and wait until every owed byte has come back.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        wait (byte_q.size() == 0);
    endtask

    function automatic logic [7:0] random_code();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return DISK_CODES[$urandom_range(63)];
    endfunction

    // Random sectors until the model has taken budget more nibbles; the
    // sector in progress is cut off there. Most are whole sectors plus
    // up to three trailing nibbles (checksum and junk); some are cut off by an early
    // start; some are raw noise with stray starts.
    task automatic run_random_sectors(input int unsigned budget);
        int unsigned target;
        int unsigned kind;
        int unsigned len;
        target = used_items + budget;
        while (used_items < target)
        begin
            kind = $urandom_range(99);
            if (kind < 90)
            begin
                if (kind < 80)
                    len = SECTOR_NIBBLES + $urandom_range(3);
                else
                    len = $urandom_range(SECTOR_NIBBLES - 1, 1);
                for (int k = 0; (k < len) && (used_items < target); k++)
                    send_nibble(random_code(), (k == 0) || ($urandom_range(999) == 0),
                                1'b0, '0);
            end
            else
            begin
                len = $urandom_range(40, 5);
                for (int k = 0; (k < len) && (used_items < target); k++)
                    send_nibble(8'($urandom_range(255)), ($urandom_range(19) == 0),
                                1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random pop, plus one long hold when armed
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                pop <= 1'b0;
                for (int n = 1; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest owed byte.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (byte_q.size() == 0)
            begin
                $error("unexpected data_byte %h at byte_index %0d", data_byte, byte_index);
                errors++;
            end
            else
            begin
                sector_byte_t head;
                head = byte_q.pop_front();
                if (data_byte !== head.data_byte)
                begin
                    $error("data_byte: expected %h, got %h", head.data_byte, data_byte);
                    errors++;
                end
                if (byte_index !== head.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d", head.byte_index, byte_index);
                    errors++;
                end
                if (last !== head.last)
                begin
                    $error("last: expected %b, got %b", head.last, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    disk_row_t dir_rows [N_DIR];

    initial
    begin
        dir_rows = '{
            // no start after reset; aux filled with zero from invalid nibbles and 0x96
            '{8'h00, 1'b0, 9'd40,  1'b0, '0},
            '{8'h96, 1'b0, 9'd46,  1'b0, '0},
            // first data bytes: all-ones value, back to zero, invalid nibble
            '{8'hFF, 1'b0, 9'd1,   1'b1, '{8'hFC, 8'd0,   1'b0}},
            '{8'hFF, 1'b0, 9'd1,   1'b1, '{8'h00, 8'd1,   1'b0}},
            '{8'h7F, 1'b0, 9'd1,   1'b1, '{8'h00, 8'd2,   1'b0}},
            '{8'h96, 1'b0, 9'd252, 1'b0, '0},
            // byte 255 closes the sector
            '{8'hFF, 1'b0, 9'd1,   1'b1, '{8'hFC, 8'd255, 1'b1}},
            // checksum and beyond: dropped
            '{8'hAA, 1'b0, 9'd3,   1'b0, '0},
            // start past the sector end; aux all ones
            '{8'hFF, 1'b1, 9'd1,   1'b0, '0},
            '{8'h96, 1'b0, 9'd85,  1'b0, '0},
            '{8'h96, 1'b0, 9'd1,   1'b1, '{8'hFF, 8'd0,   1'b0}},
            '{8'hFF, 1'b0, 9'd1,   1'b1, '{8'h03, 8'd1,   1'b0}},
            '{8'hD6, 1'b0, 9'd20,  1'b0, '0},
            // restart in the middle of the data phase, mixed fragments
            '{8'h97, 1'b1, 9'd1,   1'b0, '0},
            '{8'hEB, 1'b0, 9'd85,  1'b0, '0},
            '{8'hB5, 1'b0, 9'd40,  1'b0, '0},
            // start again in the data phase, then two starts in a row
            '{8'hFF, 1'b1, 9'd1,   1'b0, '0},
            '{8'h96, 1'b1, 9'd2,   1'b0, '0}
        };

        send_idle_pct = 17;
        recv_idle_pct = 77;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_nibble(dir_rows[r].nib, dir_rows[r].st,
                            dir_rows[r].has_want, dir_rows[r].want);
        drain_results();

        // sender mostly busy, receiver mostly stalled
        run_random_sectors(PHASE_ITEMS);
        drain_results();

        // the other way round
        send_idle_pct = 77;
        recv_idle_pct = 17;
        run_random_sectors(PHASE_ITEMS);
        drain_results();

        // no idling; result side held off so the job queue fills and full rises
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
        run_random_sectors(PHASE_ITEMS);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
